FILE: rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the text extent RTL.
// Needs clk in the scope of every use, and rst_n as well for UTM_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define UTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UTM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/utm_pkg.sv
// utm_pkg: types, codes and constants of the UTF-8 text extent unit.
// No dependencies.
`timescale 1ns / 1ps

package utm_pkg;

    localparam int PAGES_DEFAULT = 256;
    localparam int CODE_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int METRIC_W      = 16;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 16;
    localparam int EXT_W         = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [CFG_DATA_W-1:0] SIZE_Q_RESET = 16'd768;
    localparam logic [CFG_DATA_W-1:0] UPEM_RESET   = 16'd1000;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TEXT = 2'd1,
        OP_END  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_Q       = 4'd0,
        CFG_UNITS_PER_EM = 4'd1,
        CFG_DESCENT_MIN  = 4'd2,
        CFG_ASCENT_MAX   = 4'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        Q_LOAD  = 2'd0,
        Q_GLYPH = 2'd1,
        Q_END   = 2'd2
    } qkind_t;

    typedef struct packed {
        qkind_t                kind;
        logic [CODE_W-1:0]     code;
        logic [METRIC_W-1:0]   advance;
        logic [METRIC_W-1:0]   bearing;
        logic                  bad;
    } qitem_t;

    typedef enum logic [2:0] {
        B_IDLE     = 3'd0,
        B_ACC      = 3'd1,
        B_MUL      = 3'd2,
        B_DIV_GO   = 3'd3,
        B_DIV_WAIT = 3'd4,
        B_FINISH   = 3'd5
    } back_state_t;

endpackage

FILE: rtl/utm_ifs.sv
// utm_ifs: valid/ready channel interfaces of the text extent unit.
// Depends on utm_pkg.
`timescale 1ns / 1ps

interface utm_item_if;
    import utm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [CODE_W-1:0]          code_index;
    logic [BYTE_W-1:0]          byte_value;
    logic [METRIC_W-1:0]        advance;
    logic signed [METRIC_W-1:0] bearing;

    modport source (output valid, op, code_index, byte_value, advance, bearing, input ready);
    modport sink (input valid, op, code_index, byte_value, advance, bearing, output ready);
endinterface

interface utm_ext_if;
    import utm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [EXT_W-1:0] left;
    logic signed [EXT_W-1:0] bottom;
    logic signed [EXT_W-1:0] right;
    logic signed [EXT_W-1:0] top;

    modport source (output valid, ok, left, bottom, right, top, input ready);
    modport sink (input valid, ok, left, bottom, right, top, output ready);
endinterface

interface utm_cfg_if;
    import utm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/utm_front.sv
// utm_front: accepts input beats, decodes UTF-8 and queues back-end work.
// Depends on utm_pkg and utm_ifs.
`timescale 1ns / 1ps

module utm_front (
    input  logic            clk,
    input  logic            rst_n,
    utm_item_if.sink        items,
    input  logic            full,
    output logic            push,
    output utm_pkg::qitem_t push_item
);
    import utm_pkg::*;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hf8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hf0;
    localparam logic [BYTE_W-1:0] PAY2_MASK  = 8'h1f;
    localparam logic [BYTE_W-1:0] PAY3_MASK  = 8'h0f;
    localparam logic [BYTE_W-1:0] PAY4_MASK  = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_PAY   = 8'h3f;
    localparam int CP_W = 21;

    logic [CP_W-1:0]   code_reg, code_next;
    logic [1:0]        pending_reg, pending_next;
    logic              failed_reg, failed_next;

    logic              accept;
    logic              glyph;
    logic [CP_W-1:0]   cp;
    logic [CP_W-1:0]   cont_code;
    logic [BYTE_W-1:0] b;

    assign items.ready = !full;
    assign accept      = items.valid && items.ready;
    assign b           = items.byte_value;
    assign cont_code   = {code_reg[CP_W-7:0], 6'(b & CONT_PAY)};

    always_comb
    begin
        code_next         = code_reg;
        pending_next      = pending_reg;
        failed_next       = failed_reg;
        glyph             = 1'b0;
        cp                = '0;
        push              = 1'b0;
        push_item.kind    = Q_GLYPH;
        push_item.code    = items.code_index;
        push_item.advance = items.advance;
        push_item.bearing = items.bearing;
        push_item.bad     = 1'b0;
        if (accept)
        begin
            unique case (op_t'(items.op))
                OP_LOAD:
                begin
                    push           = 1'b1;
                    push_item.kind = Q_LOAD;
                end
                OP_TEXT:
                begin
                    if (!failed_reg)
                    begin
                        if (pending_reg != 2'd0)
                        begin
                            if ((b & CONT_MASK) != CONT_CODE)
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                code_next    = cont_code;
                                pending_next = pending_reg - 2'd1;
                                if (pending_reg == 2'd1)
                                begin
                                    glyph = 1'b1;
                                    cp    = cont_code;
                                end
                            end
                        end
                        else if (!b[BYTE_W-1])
                        begin
                            glyph = 1'b1;
                            cp    = CP_W'(b);
                        end
                        else if ((b & LEAD2_MASK) == LEAD2_CODE)
                        begin
                            code_next    = CP_W'(b & PAY2_MASK);
                            pending_next = 2'd1;
                        end
                        else if ((b & LEAD3_MASK) == LEAD3_CODE)
                        begin
                            code_next    = CP_W'(b & PAY3_MASK);
                            pending_next = 2'd2;
                        end
                        else if ((b & LEAD4_MASK) == LEAD4_CODE)
                        begin
                            code_next    = CP_W'(b & PAY4_MASK);
                            pending_next = 2'd3;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    // code points above 16 bits have no metric
                    if (glyph && (cp[CP_W-1:CODE_W] == '0))
                    begin
                        push           = 1'b1;
                        push_item.kind = Q_GLYPH;
                        push_item.code = cp[CODE_W-1:0];
                    end
                end
                OP_END:
                begin
                    push           = 1'b1;
                    push_item.kind = Q_END;
                    push_item.bad  = failed_reg || (pending_reg != 2'd0);
                    code_next      = '0;
                    pending_next   = 2'd0;
                    failed_next    = 1'b0;
                end
                OP_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg    <= '0;
            pending_reg <= 2'd0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            code_reg    <= code_next;
            pending_reg <= pending_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

FILE: rtl/utm_queue.sv
// utm_queue: short FIFO of work items between front and back end.
// Depends on utm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utm_pkg::qitem_t push_item,
    input  logic            pop,
    output utm_pkg::qitem_t head,
    output logic            full,
    output logic            empty
);
    import utm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qitem_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    `UTM_ASSERT_RST(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
    `UTM_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
    `UTM_ASSERT(a_no_pop_empty, pop |-> !empty, "pop from empty queue")

endmodule

FILE: rtl/utm_div.sv
// utm_div: restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module utm_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] acc_reg, acc_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg[DEN_W-1:0], acc_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign busy  = busy_reg;
    assign done  = done_reg;
    assign quot  = acc_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (trial - {1'b0, den_reg}) : trial;
            acc_next = {acc_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

FILE: rtl/utm_back.sv
// utm_back: metric memory, page flags, advance sum and extent scaling.
// Depends on utm_pkg, utm_ifs, utm_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utm_back #(
    parameter int PAGES = utm_pkg::PAGES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    utm_cfg_if.sink         cfg,
    utm_ext_if.source       extents,
    input  utm_pkg::qitem_t head,
    input  logic            empty,
    output logic            pop
);
    import utm_pkg::*;

    localparam int SUM_W      = 32;
    localparam int PROD_W     = SUM_W + CFG_DATA_W;
    localparam int QVAL_W     = PROD_W + 1;
    localparam int WIDE_W     = PROD_W + 2;
    localparam int PAGE_W     = CODE_W - 8;
    localparam int PAGE_SLOTS = (PAGES < (1 << PAGE_W)) ? PAGES : (1 << PAGE_W);
    localparam int PIDX_W     = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int MEM_DEPTH  = 1 << CODE_W;

    localparam logic signed [WIDE_W-1:0] SAT_MAX =
        {{(WIDE_W-EXT_W+1){1'b0}}, {(EXT_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SAT_MIN =
        {{(WIDE_W-EXT_W+1){1'b1}}, {(EXT_W-1){1'b0}}};

    function automatic logic signed [EXT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [EXT_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[EXT_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[EXT_W-1:0];
        end
        else
        begin
            r = v[EXT_W-1:0];
        end
        return r;
    endfunction

    back_state_t              state_reg, state_next;
    logic [1:0]               k_reg, k_next;
    logic [CFG_DATA_W-1:0]    size_reg, size_next;
    logic [CFG_DATA_W-1:0]    upem_reg, upem_next;
    logic [CFG_DATA_W-1:0]    descent_reg, descent_next;
    logic [CFG_DATA_W-1:0]    ascent_reg, ascent_next;
    logic [PAGE_SLOTS-1:0]    page_present_reg, page_present_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [METRIC_W-1:0]      fb_reg, fb_next;
    logic                     seen_reg, seen_next;
    logic                     out_valid_reg, out_valid_next;

    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic signed [QVAL_W-1:0] res_left_reg, res_left_next;
    logic signed [QVAL_W-1:0] res_bottom_reg, res_bottom_next;
    logic signed [QVAL_W-1:0] res_sum_reg, res_sum_next;
    logic signed [QVAL_W-1:0] res_top_reg, res_top_next;
    logic                     ok_reg, ok_next;
    logic signed [EXT_W-1:0]  left_reg, left_next;
    logic signed [EXT_W-1:0]  bottom_reg, bottom_next;
    logic signed [EXT_W-1:0]  right_reg, right_next;
    logic signed [EXT_W-1:0]  top_reg, top_next;

    logic [2*METRIC_W-1:0]    mem [MEM_DEPTH];
    logic [2*METRIC_W-1:0]    rd_data_reg;
    logic                     mem_we;
    logic                     mem_re;

    logic [PAGE_W-1:0]        page;
    logic [PIDX_W-1:0]        page_idx;
    logic                     page_ok;
    logic                     present;
    logic                     end_pop;
    logic signed [SUM_W:0]    sval;
    logic signed [SUM_W:0]    mag_s;
    logic [SUM_W-1:0]         mag;
    logic [PROD_W-1:0]        prod;
    logic signed [QVAL_W-1:0] qsigned;
    logic signed [WIDE_W-1:0] right_wide;
    logic [SUM_W:0]           sum_add;

    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quot;

    utm_div #(
        .NUM_W (PROD_W),
        .DEN_W (CFG_DATA_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (upem_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign cfg.ready       = 1'b1;
    assign extents.valid   = out_valid_reg;
    assign extents.ok      = ok_reg;
    assign extents.left    = left_reg;
    assign extents.bottom  = bottom_reg;
    assign extents.right   = right_reg;
    assign extents.top     = top_reg;

    assign page      = head.code[CODE_W-1:CODE_W-PAGE_W];
    assign page_idx  = page[PIDX_W-1:0];
    assign page_ok   = (int'(page) < PAGES);
    assign present   = page_ok && page_present_reg[page_idx];
    assign div_start = (state_reg == B_DIV_GO);
    assign prod      = mag * size_reg;
    assign qsigned   = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    assign right_wide = WIDE_W'(res_sum_reg) + WIDE_W'(res_left_reg);
    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(rd_data_reg[METRIC_W-1:0]);

    // operand of the current scaling step
    always_comb
    begin
        case (k_reg)
            2'd0:    sval = -$signed({{(SUM_W-METRIC_W+1){fb_reg[METRIC_W-1]}}, fb_reg});
            2'd1:    sval = $signed({1'b0, sum_reg});
            2'd2:    sval = $signed({{(SUM_W-METRIC_W+1){descent_reg[METRIC_W-1]}},
                                     descent_reg});
            default: sval = $signed({{(SUM_W-METRIC_W+1){ascent_reg[METRIC_W-1]}},
                                     ascent_reg});
        endcase
        mag_s = sval[SUM_W] ? -sval : sval;
        mag   = mag_s[SUM_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        size_next         = size_reg;
        upem_next         = upem_reg;
        descent_next      = descent_reg;
        ascent_next       = ascent_reg;
        page_present_next = page_present_reg;
        sum_next          = sum_reg;
        fb_next           = fb_reg;
        seen_next         = seen_reg;
        out_valid_next    = out_valid_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        res_left_next     = res_left_reg;
        res_bottom_next   = res_bottom_reg;
        res_sum_next      = res_sum_reg;
        res_top_next      = res_top_reg;
        ok_next           = ok_reg;
        left_next         = left_reg;
        bottom_next       = bottom_reg;
        right_next        = right_reg;
        top_next          = top_reg;
        pop               = 1'b0;
        end_pop           = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;

        if (out_valid_reg && extents.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.reg_index))
                CFG_SIZE_Q:       size_next    = cfg.wdata;
                CFG_UNITS_PER_EM: upem_next    = cfg.wdata;
                CFG_DESCENT_MIN:  descent_next = cfg.wdata;
                CFG_ASCENT_MAX:   ascent_next  = cfg.wdata;
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    case (head.kind)
                        Q_LOAD:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                            if (page_ok)
                            begin
                                page_present_next[page_idx] = 1'b1;
                            end
                        end
                        Q_GLYPH:
                        begin
                            pop = 1'b1;
                            if (present)
                            begin
                                mem_re     = 1'b1;
                                state_next = B_ACC;
                            end
                        end
                        Q_END:
                        begin
                            if (!out_valid_reg)
                            begin
                                pop     = 1'b1;
                                end_pop = 1'b1;
                                if (head.bad || (size_reg == '0) || (upem_reg == '0))
                                begin
                                    out_valid_next = 1'b1;
                                    ok_next        = 1'b0;
                                    left_next      = '0;
                                    bottom_next    = '0;
                                    right_next     = '0;
                                    top_next       = '0;
                                    sum_next       = '0;
                                    fb_next        = '0;
                                    seen_next      = 1'b0;
                                end
                                else
                                begin
                                    k_next     = 2'd0;
                                    state_next = B_MUL;
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            B_ACC:
            begin
                sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                if (!seen_reg)
                begin
                    fb_next   = rd_data_reg[2*METRIC_W-1:METRIC_W];
                    seen_next = 1'b1;
                end
                state_next = B_IDLE;
            end
            B_MUL:
            begin
                prod_next  = prod;
                neg_next   = sval[SUM_W];
                state_next = B_DIV_GO;
            end
            B_DIV_GO:
            begin
                state_next = B_DIV_WAIT;
            end
            B_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (k_reg)
                        2'd0:    res_left_next   = qsigned;
                        2'd1:    res_sum_next    = qsigned;
                        2'd2:    res_bottom_next = qsigned;
                        default: res_top_next    = qsigned;
                    endcase
                    if (k_reg == 2'd3)
                    begin
                        state_next = B_FINISH;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = B_MUL;
                    end
                end
            end
            B_FINISH:
            begin
                out_valid_next = 1'b1;
                ok_next        = 1'b1;
                left_next      = sat32(WIDE_W'(res_left_reg));
                bottom_next    = sat32(WIDE_W'(res_bottom_reg));
                right_next     = sat32(right_wide);
                top_next       = sat32(WIDE_W'(res_top_reg));
                sum_next       = '0;
                fb_next        = '0;
                seen_next      = 1'b0;
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            k_reg            <= 2'd0;
            size_reg         <= SIZE_Q_RESET;
            upem_reg         <= UPEM_RESET;
            descent_reg      <= '0;
            ascent_reg       <= '0;
            page_present_reg <= '0;
            sum_reg          <= '0;
            fb_reg           <= '0;
            seen_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            size_reg         <= size_next;
            upem_reg         <= upem_next;
            descent_reg      <= descent_next;
            ascent_reg       <= ascent_next;
            page_present_reg <= page_present_next;
            sum_reg          <= sum_next;
            fb_reg           <= fb_next;
            seen_reg         <= seen_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        res_left_reg   <= res_left_next;
        res_bottom_reg <= res_bottom_next;
        res_sum_reg    <= res_sum_next;
        res_top_reg    <= res_top_next;
        ok_reg         <= ok_next;
        left_reg       <= left_next;
        bottom_reg     <= bottom_next;
        right_reg      <= right_next;
        top_reg        <= top_next;
    end

    // metric memory: advance low half, bearing high half
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head.code] <= {head.bearing, head.advance};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[head.code];
        end
    end

    `UTM_ASSERT(a_pop_idle, pop |-> (state_reg == B_IDLE), "queue pop outside idle")
    `UTM_ASSERT(a_div_free, div_start |-> !div_busy, "divider restarted while busy")
    `UTM_ASSERT(a_sum_mono, (state_reg == B_ACC) |=> (sum_reg >= $past(sum_reg)),
        "advance sum decreased")
    `UTM_ASSERT(a_out_source, $rose(out_valid_reg) |->
        (($past(state_reg) == B_FINISH) || $past(end_pop)), "result without end item")

endmodule

FILE: rtl/utf8_text_extent_measure_unit.sv
// Channel   Dir  Beat
// cfg       in   register write: reg_index, wdata (always ready)
// items     in   load metric / text byte / end of string
// extents   out  ok, left, bottom, right, top in 1/64 pt
//
// Front end takes one beat per cycle while the 4-entry queue has room.
// Back end: a glyph on a present page does a memory read, then B_ACC.
// End of string: four 48-bit divisions in turn on one divider.
// No clearing pass after reset; page flags reset at once, metrics undefined.
// A pending result blocks only the next end item in the back end.
// Depends on utm_pkg, utm_ifs, utm_front, utm_queue, utm_back.
`timescale 1ns / 1ps

module utf8_text_extent_measure_unit #(
    parameter int PAGES = utm_pkg::PAGES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    utm_cfg_if.sink   cfg,
    utm_item_if.sink  items,
    utm_ext_if.source extents
);
    import utm_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    qitem_t push_item;
    qitem_t head;

    utm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    utm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    utm_back #(
        .PAGES (PAGES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .extents (extents),
        .head    (head),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
